// ----- hdl/aes128_pkg.sv -----
// ----------------------------------------------------------------------------
// aes128_pkg: shared types and functions for the aes-128 encryption pipeline
// sbox, gf doubling, round constants and the cell-to-cell bundle
// ----------------------------------------------------------------------------
package aes128_pkg;

  localparam int unsigned BlockW = 128;
  localparam int unsigned NumRounds = 10;

  typedef logic [BlockW-1:0] block_t;

  // data handed from one round cell to the next
  typedef struct packed {
    logic   valid;
    block_t state;
    block_t rkey;
    logic [7:0] rcon;
  } stage_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] RconFirst = 8'h01;

  // multiply by x modulo x^8 + x^4 + x^3 + x + 1
  function automatic logic [7:0] gf_double(input logic [7:0] a);
    gf_double = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // byte i of a block, byte 0 in the top bits
  function automatic logic [7:0] get_byte(input block_t b, input int unsigned i);
    get_byte = b[BlockW-1-8*i -: 8];
  endfunction

endpackage

// ----- hdl/aes128_round.sv -----
// ----------------------------------------------------------------------------
// aes128_round: one aes round cell
// sub bytes, shift rows, optional mix columns, key expansion and add key
// ----------------------------------------------------------------------------
module aes128_round #(
  parameter bit LastRound = 1'b0
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  aes128_pkg::stage_t  prev_i,
  output aes128_pkg::stage_t  next_o
);

  logic [7:0] s   [16];
  logic [7:0] t   [16];
  logic [7:0] m   [16];
  logic [7:0] k   [16];
  logic [7:0] nk  [16];
  aes128_pkg::block_t state_d, key_d;
  logic               valid_q;
  aes128_pkg::block_t state_q, rkey_q;
  logic [7:0]         rcon_q;

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      s[i] = aes128_pkg::get_byte(prev_i.state, i);
      k[i] = aes128_pkg::get_byte(prev_i.rkey, i);
    end
    // sub bytes with row shift
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[c*4+r] = aes128_pkg::SBOX[s[((c + r) % 4) * 4 + r]];
      end
    end
    for (int c = 0; c < 4; c++) begin
      m[c*4]   = aes128_pkg::gf_double(t[c*4]) ^ aes128_pkg::gf_double(t[c*4+1])
                 ^ t[c*4+1] ^ t[c*4+2] ^ t[c*4+3];
      m[c*4+1] = t[c*4] ^ aes128_pkg::gf_double(t[c*4+1]) ^ aes128_pkg::gf_double(t[c*4+2])
                 ^ t[c*4+2] ^ t[c*4+3];
      m[c*4+2] = t[c*4] ^ t[c*4+1] ^ aes128_pkg::gf_double(t[c*4+2])
                 ^ aes128_pkg::gf_double(t[c*4+3]) ^ t[c*4+3];
      m[c*4+3] = aes128_pkg::gf_double(t[c*4]) ^ t[c*4] ^ t[c*4+1] ^ t[c*4+2]
                 ^ aes128_pkg::gf_double(t[c*4+3]);
    end
    // key expansion
    nk[0] = k[0] ^ aes128_pkg::SBOX[k[13]] ^ prev_i.rcon;
    nk[1] = k[1] ^ aes128_pkg::SBOX[k[14]];
    nk[2] = k[2] ^ aes128_pkg::SBOX[k[15]];
    nk[3] = k[3] ^ aes128_pkg::SBOX[k[12]];
    for (int i = 4; i < 16; i++) begin
      nk[i] = k[i] ^ nk[i-4];
    end
    for (int i = 0; i < 16; i++) begin
      key_d[aes128_pkg::BlockW-1-8*i -: 8]   = nk[i];
      state_d[aes128_pkg::BlockW-1-8*i -: 8] = (LastRound ? t[i] : m[i]) ^ nk[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= prev_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      state_q <= state_d;
      rkey_q  <= key_d;
      rcon_q  <= aes128_pkg::gf_double(prev_i.rcon);
    end
  end

  assign next_o = '{valid: valid_q, state: state_q, rkey: rkey_q, rcon: rcon_q};

endmodule

// ----- hdl/aes128_block_encrypt.sv -----
// ----------------------------------------------------------------------------
// aes128_block_encrypt: aes-128 block encryption, one block per cycle while the output is not stalled
// a chain of round cells with the key expanded alongside the data
// ----------------------------------------------------------------------------
//  channel  | dir | fields (tdata low bit up)
//  s_axis   | in  | plaintext_high [63:0], plaintext_low [127:64]
//  m_axis   | out | ciphertext_high [63:0], ciphertext_low [127:64]
//  cfg      | in  | index 0 key_high, index 1 key_low, 64-bit data
//
// the chain is the initial key add stage plus one cell per round
// a new block request is taken every cycle while the chain advances
// the whole chain advances when the last cell is empty or its result is taken,
// so a stall at the output freezes all cells
// reset clears the valid flags and both key registers
module aes128_block_encrypt (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [127:0]  s_axis_tdata,   // plaintext_high, plaintext_low
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [127:0]  m_axis_tdata,   // ciphertext_high, ciphertext_low
  input  logic          cfg_we_i,
  input  logic          cfg_index_i,
  input  logic [63:0]   cfg_data_i
);

  localparam logic CfgKeyHigh = 1'b0;
  localparam logic CfgKeyLow  = 1'b1;

  logic [63:0] key_high_q, key_low_q;
  logic        advance;
  aes128_pkg::stage_t chain [aes128_pkg::NumRounds+1];
  logic               entry_valid_q;
  aes128_pkg::block_t entry_state_q, entry_rkey_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_high_q <= '0;
      key_low_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgKeyHigh: key_high_q <= cfg_data_i;
        CfgKeyLow:  key_low_q  <= cfg_data_i;
        default:    ;
      endcase
    end
  end

  assign advance       = !chain[aes128_pkg::NumRounds].valid || m_axis_tready;
  assign s_axis_tready = advance;

  // initial add of the cipher key
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_valid_q <= 1'b0;
    end else if (advance) begin
      entry_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      entry_state_q <= {s_axis_tdata[63:0], s_axis_tdata[127:64]}
                       ^ {key_high_q, key_low_q};
      entry_rkey_q  <= {key_high_q, key_low_q};
    end
  end

  assign chain[0] = '{valid: entry_valid_q, state: entry_state_q, rkey: entry_rkey_q,
                      rcon: aes128_pkg::RconFirst};

  for (genvar r = 0; r < aes128_pkg::NumRounds; r++) begin : g_round
    aes128_round #(
      .LastRound(r == aes128_pkg::NumRounds - 1)
    ) u_round (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .en_i  (advance),
      .prev_i(chain[r]),
      .next_o(chain[r+1])
    );
  end

  assign m_axis_tvalid = chain[aes128_pkg::NumRounds].valid;
  assign m_axis_tdata  = {chain[aes128_pkg::NumRounds].state[63:0],
                          chain[aes128_pkg::NumRounds].state[127:64]};

  // a stalled result stays put
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed under stall");

  // ready follows the output stage
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input blocked with empty output");

  // a request taken into the entry stage marks it valid
  a_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> entry_valid_q)
    else $error("accepted request lost");

endmodule

// ----- tb/sv/tb_aes128_block_encrypt.sv -----
// ----------------------------------------------------------------------------
// tb_aes128_block_encrypt: self-checking bench for the aes-128 encrypt pipeline
// plaintext blocks under several keys, compared against a behavioral cipher
// ----------------------------------------------------------------------------
module tb_aes128_block_encrypt;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic KeyHighIdx = 1'b0;
  localparam logic KeyLowIdx  = 1'b1;
  localparam int   Latency    = 11;
  localparam int   CycleLimit = 400000;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [127:0] s_axis_tdata;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [127:0] m_axis_tdata;
  logic         cfg_we_i;
  logic         cfg_index_i;
  logic [63:0]  cfg_data_i;

  aes128_block_encrypt DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),   // plaintext_high, plaintext_low
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),   // ciphertext_high, ciphertext_low
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  // plaintext blocks waiting for the driver, ciphertexts waiting for the monitor
  // both held as {high, low}
  logic [127:0] plain_q[$];
  logic [127:0] cipher_q[$];

  // key as seen by the block, mirrored on every write
  logic [63:0]  key_hi, key_lo;
  int           send_idle_pct, recv_idle_pct;
  bit           hold_send;
  int           errors = 0;
  longint       cycles = 0;

  // ---- behavioral cipher ----------------------------------------------------
  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // state bytes indexed column-major, byte 0 at the top of the 128-bit word
  function automatic logic [127:0] encrypt_block(input logic [127:0] pt,
                                                 input logic [127:0] key);
    logic [7:0] st[16];
    logic [7:0] rk[16];
    logic [7:0] tmp[16];
    logic [7:0] t0, t1, t2, t3, a0, a1, a2, a3;
    logic [7:0] rcon;
    logic [127:0] ct;
    rcon = 8'h01;
    for (int i = 0; i < 16; i++) begin
      st[i] = pt[127-8*i -: 8] ^ key[127-8*i -: 8];
      rk[i] = key[127-8*i -: 8];
    end
    for (int r = 1; r <= 10; r++) begin
      // sub bytes with shift rows folded in
      for (int c = 0; c < 4; c++)
        for (int w = 0; w < 4; w++)
          tmp[c*4+w] = aes128_pkg::SBOX[st[((c+w)%4)*4+w]];
      st = tmp;
      if (r != 10) begin
        for (int c = 0; c < 4; c++) begin
          a0 = st[c*4]; a1 = st[c*4+1]; a2 = st[c*4+2]; a3 = st[c*4+3];
          st[c*4]   = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
          st[c*4+1] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
          st[c*4+2] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
          st[c*4+3] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
        end
      end
      // next round key
      t0 = aes128_pkg::SBOX[rk[13]] ^ rcon; t1 = aes128_pkg::SBOX[rk[14]];
      t2 = aes128_pkg::SBOX[rk[15]];        t3 = aes128_pkg::SBOX[rk[12]];
      rk[0] ^= t0; rk[1] ^= t1; rk[2] ^= t2; rk[3] ^= t3;
      for (int i = 4; i < 16; i++) rk[i] ^= rk[i-4];
      rcon = xtime(rcon);
      for (int i = 0; i < 16; i++) st[i] ^= rk[i];
    end
    for (int i = 0; i < 16; i++) ct[127-8*i -: 8] = st[i];
    return ct;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // ---- clock and cycle limit ------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout at %0t", $time);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // ---- driver: one request per accepted handshake ---------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      // current request (if any) taken this edge; queue the next one
      if (plain_q.size() > 0 && !hold_send &&
          $urandom_range(99) >= send_idle_pct) begin
        s_axis_tvalid <= 1'b1;
        // plaintext_high in the low half of tdata, byte 0 on top of it
        s_axis_tdata  <= {plain_q[0][63:0], plain_q[0][127:64]};
        cipher_q.push_back(encrypt_block(plain_q[0], {key_hi, key_lo}));
        void'(plain_q.pop_front());
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // ---- monitor and receiver stalls ------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (cipher_q.size() == 0) begin
          $display("%0t: unexpected ciphertext %h", $time, m_axis_tdata);
          errors++;
        end else begin
          if (m_axis_tdata[63:0] !== cipher_q[0][127:64]) begin
            $display("%0t: ciphertext_high expected %h actual %h", $time,
                     cipher_q[0][127:64], m_axis_tdata[63:0]);
            errors++;
          end
          if (m_axis_tdata[127:64] !== cipher_q[0][63:0]) begin
            $display("%0t: ciphertext_low expected %h actual %h", $time,
                     cipher_q[0][63:0], m_axis_tdata[127:64]);
            errors++;
          end
          void'(cipher_q.pop_front());
        end
      end
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // ---- stimulus sequencing --------------------------------------------------
  task automatic write_key(input logic idx, input logic [63:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    if (idx == KeyHighIdx) key_hi = val;
    else key_lo = val;
  endtask

  // block idle: nothing queued, nothing in flight, nothing expected
  task automatic drain();
    while (plain_q.size() > 0 || s_axis_tvalid || cipher_q.size() > 0)
      @(posedge clk_i);
    repeat (Latency + 2) @(posedge clk_i);
  endtask

  task automatic random_blocks(input int n);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(9))
        0:       plain_q.push_back('0);
        1:       plain_q.push_back('1);
        2:       plain_q.push_back({rand64(), 64'h0});
        default: plain_q.push_back({rand64(), rand64()});
      endcase
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_index_i   = KeyHighIdx;
    cfg_data_i    = '0;
    key_hi        = '0;
    key_lo        = '0;
    hold_send     = 1'b0;
    send_idle_pct = 24;
    recv_idle_pct = 77;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // all-zero key straight out of reset
    plain_q.push_back('0);
    plain_q.push_back('1);
    plain_q.push_back(128'h00112233445566778899aabbccddeeff);
    drain();

    // published test vector key, then the all-ones key
    write_key(KeyHighIdx, 64'h0001020304050607);
    write_key(KeyLowIdx,  64'h08090a0b0c0d0e0f);
    plain_q.push_back(128'h00112233445566778899aabbccddeeff);
    plain_q.push_back(128'h8000000000000000_0000000000000001);
    plain_q.push_back(128'h0000000000000001_8000000000000000);
    drain();
    write_key(KeyHighIdx, '1);
    write_key(KeyLowIdx,  '1);
    plain_q.push_back('0);
    plain_q.push_back('1);
    plain_q.push_back(128'h5555555555555555_aaaaaaaaaaaaaaaa);
    drain();

    // random phases, fresh key each time, idle mix changing per third
    for (int ph = 0; ph < 9; ph++) begin
      if (ph == 3) begin send_idle_pct = 77; recv_idle_pct = 24; end
      if (ph == 6) begin send_idle_pct = 0;  recv_idle_pct = 0;  end
      write_key(KeyHighIdx, (ph == 4) ? 64'h0 : rand64());
      write_key(KeyLowIdx,  (ph == 5) ? 64'h0 : rand64());
      random_blocks(45);
      // sender holds off until every ciphertext is back
      while (plain_q.size() > 0 || s_axis_tvalid) @(posedge clk_i);
      hold_send = 1'b1;
      while (cipher_q.size() > 0) @(posedge clk_i);
      hold_send = 1'b0;
      random_blocks(45);
      drain();
    end

    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- aes128_block_encrypt.f -----
hdl/aes128_pkg.sv
hdl/aes128_round.sv
hdl/aes128_block_encrypt.sv
tb/sv/tb_aes128_block_encrypt.sv
